@@ sv/modular_exponentiation_core_defines.svh @@
// ----------------------------------------------------------------------------
// Modular exponentiation core: assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEC_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, register indexes, controller states and the multiplier request type.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int FIELD_W   = 64;              // port field width
    localparam int OPW       = 64;              // operand width actually used
    localparam int CNT_W     = $clog2(OPW);     // bit counter width
    localparam int EXT_W     = OPW + 3;         // step sum width, with sign bit
    localparam int CFG_IDX_W = 8;

    typedef logic [FIELD_W-1:0]   field_t;
    typedef logic [OPW-1:0]       operand_t;
    typedef logic [CNT_W-1:0]     bit_cnt_t;
    typedef logic [EXT_W-1:0]     ext_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_MODULUS  = cfg_index_t'(0);
    localparam cfg_index_t REG_EXPONENT = cfg_index_t'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_REDUCE_WAIT,
        ST_EXP_START,
        ST_EXP_WAIT,
        ST_DONE
    } state_t;

    // Request to a modular multiplier: product = multiplicand * multiplier mod m
    typedef struct packed {
        logic     start;
        operand_t multiplicand;
        operand_t multiplier;
    } mul_req_t;

endpackage

@@ sv/modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation core
// base^exponent mod modulus, right-to-left square-and-multiply, bit-serial.
// ----------------------------------------------------------------------------
// Each input transaction carries one base; one output transaction returns
// base^exponent mod modulus, with modulus and exponent taken from the config
// registers (index 0 modulus, reset 1; index 1 exponent, reset 0). A base that
// reduces to zero gives 0, also for a zero exponent; a zero modulus gives 0.
// One item is worked on at a time: the base is first reduced in one pass of a
// bit-serial multiplier, then each of the OPW exponent bits costs one square
// and one conditional multiply, run side by side in two bit-serial
// multipliers that retire one multiplier bit per cycle. A zero modulus or a
// base that reduces to zero skips the exponent loop. A finished result sits
// in the output register, so the next base can be accepted before the
// previous result is taken.
// Config writes are always accepted and must only happen while idle.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_defines.svh"

module modular_exponentiation_core (
    input  logic                 clk,
    input  logic                 rst_n,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  mexp_pkg::cfg_index_t cfg_index,
    input  mexp_pkg::field_t     cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  mexp_pkg::field_t     s_axis_tdata,   // [63:0] base_value
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output mexp_pkg::field_t     m_axis_tdata    // [63:0] power_result
);
    import mexp_pkg::*;

    // config registers
    field_t   modulus_reg;
    field_t   exponent_reg;

    // controller
    state_t   state_reg, state_next;
    bit_cnt_t bit_cnt_reg, bit_cnt_next;

    // datapath
    operand_t base_reg;
    operand_t exp_sh_reg;     // exponent, shifted right one bit per iteration
    operand_t sq_reg;         // running square of the reduced base
    operand_t acc_reg;        // running product, final result

    // output register
    logic     out_valid_reg, out_valid_next;
    field_t   out_data_reg;

    operand_t mod_op;
    logic     in_fire;
    logic     out_load;
    logic     last_bit;
    mul_req_t sq_req;
    mul_req_t acc_req;
    logic     sq_done;
    logic     acc_done;
    operand_t sq_product;
    operand_t acc_product;

    assign mod_op   = modulus_reg[OPW-1:0];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign last_bit = (bit_cnt_reg == CNT_W'(OPW - 1));

    // ------------------------------------------------------------------------
    // Config port: never stalls; unknown indexes are dropped.
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= field_t'(1);
            exponent_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODULUS:  modulus_reg  <= cfg_data;
                REG_EXPONENT: exponent_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Multipliers: the square unit also does the initial base reduction
    // (1 * base mod m).
    // ------------------------------------------------------------------------
    mexp_mulmod u_sq_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sq_req),
        .modulus (mod_op),
        .done    (sq_done),
        .product (sq_product)
    );

    mexp_mulmod u_acc_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (acc_req),
        .modulus (mod_op),
        .done    (acc_done),
        .product (acc_product)
    );

    // ------------------------------------------------------------------------
    // Controller: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (mod_op == '0) ? ST_DONE : ST_REDUCE;
            end
            ST_REDUCE:
                state_next = ST_REDUCE_WAIT;
            ST_REDUCE_WAIT:
            begin
                if (sq_done)
                    state_next = (sq_product == '0) ? ST_DONE : ST_EXP_START;
            end
            ST_EXP_START:
                state_next = ST_EXP_WAIT;
            ST_EXP_WAIT:
            begin
                if (acc_done)
                    state_next = last_bit ? ST_DONE : ST_EXP_START;
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Controller: outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready        = 1'b0;
        out_load             = 1'b0;
        sq_req.start         = 1'b0;
        sq_req.multiplicand  = sq_reg;
        sq_req.multiplier    = sq_reg;
        acc_req.start        = 1'b0;
        acc_req.multiplicand = acc_reg;
        acc_req.multiplier   = sq_reg;
        unique case (state_reg)
            ST_IDLE:
                s_axis_tready = 1'b1;
            ST_REDUCE:
            begin
                sq_req.start        = 1'b1;
                sq_req.multiplicand = operand_t'(1);
                sq_req.multiplier   = base_reg;
            end
            ST_EXP_START:
            begin
                sq_req.start  = 1'b1;
                acc_req.start = 1'b1;
            end
            ST_DONE:
                out_load = !out_valid_reg || m_axis_tready;
            default:
                ;
        endcase
    end

    always_comb
    begin
        bit_cnt_next = bit_cnt_reg;
        if (in_fire)
            bit_cnt_next = '0;
        else if (state_reg == ST_EXP_WAIT && acc_done)
            bit_cnt_next = bit_cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // acc starts at 1 (0 for a zero modulus); modulus 1 never reaches the loop
    // since every base reduces to zero there.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            base_reg   <= s_axis_tdata[OPW-1:0];
            exp_sh_reg <= exponent_reg[OPW-1:0];
            acc_reg    <= (mod_op == '0) ? '0 : operand_t'(1);
        end
        else if (state_reg == ST_REDUCE_WAIT && sq_done)
        begin
            sq_reg <= sq_product;
            if (sq_product == '0)
                acc_reg <= '0;
        end
        else if (state_reg == ST_EXP_WAIT && acc_done)
        begin
            if (exp_sh_reg[0])
                acc_reg <= acc_product;
            sq_reg     <= sq_product;
            exp_sh_reg <= exp_sh_reg >> 1;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= FIELD_W'(acc_reg);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `MEC_ASSERT_HOLDS(a_mul_lockstep, state_reg == ST_EXP_WAIT, acc_done == sq_done, "multipliers out of step")
    `MEC_ASSERT_HOLDS(a_sq_reduced, state_reg == ST_EXP_START, sq_reg < mod_op, "square not reduced")
    `MEC_ASSERT_HOLDS(a_acc_reduced, state_reg == ST_EXP_START, acc_reg < mod_op, "accumulator not reduced")
    `MEC_ASSERT_NEXT(a_out_load, out_load, m_axis_tvalid && (m_axis_tdata == FIELD_W'($past(acc_reg))), "result not loaded")

endmodule

@@ sv/mexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved double-and-add, one multiplier bit per cycle from the MSB down.
// ----------------------------------------------------------------------------
module mexp_mulmod (
    input  logic               clk,
    input  logic               rst_n,
    input  mexp_pkg::mul_req_t req,
    input  mexp_pkg::operand_t modulus,
    output logic               done,
    output mexp_pkg::operand_t product
);
    import mexp_pkg::*;

    logic     busy_reg, busy_next;
    logic     done_reg, done_next;
    bit_cnt_t cnt_reg,  cnt_next;
    operand_t acc_reg,  acc_next;
    operand_t a_reg;
    operand_t b_reg;
    operand_t m_reg;

    ext_t dbl;
    ext_t addend;
    ext_t sum0;
    ext_t sum1;
    ext_t sum2;
    logic last;

    // acc < m and a < m keep 2*acc + a below 3m: subtract 0, m or 2m.
    always_comb
    begin
        dbl    = ext_t'(acc_reg) << 1;
        addend = b_reg[OPW-1] ? ext_t'(a_reg) : '0;
        sum0   = dbl + addend;
        sum1   = dbl + addend - ext_t'(m_reg);
        sum2   = dbl + addend - (ext_t'(m_reg) << 1);
        if (!sum2[EXT_W-1])
            acc_next = sum2[OPW-1:0];
        else if (!sum1[EXT_W-1])
            acc_next = sum1[OPW-1:0];
        else
            acc_next = sum0[OPW-1:0];
    end

    assign last = (cnt_reg == CNT_W'(OPW - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= req.multiplicand;
            b_reg   <= req.multiplier;
            m_reg   <= modulus;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation core testbench
// Streams bases through the core under a series of modulus/exponent settings
// and checks every returned power against a golden square-and-multiply
// computed with exact double-width products.
// ----------------------------------------------------------------------------
// Layout:
//   - initial block: reset, register programming while the core is idle,
//     base generation into a pending queue (directed set first, then random)
//   - driver:   negedge process feeding s_axis from the pending queue with
//               random idle bursts
//   - receiver: negedge process driving m_axis_tready with random stall
//               bursts and, on request, one long hold-off
//   - monitor:  posedge process tracking the register copy, predicting each
//               accepted base and comparing each output transaction
// ----------------------------------------------------------------------------
module tb_top;
    import mexp_pkg::*;

    // Cycle limit sized for the slowest legal run: ~140 bases, each with its core
    // time, send gap and stall, plus the long hold-off and settle pauses.
    localparam int CYCLE_LIMIT        = 3_000_000;
    localparam int LONG_HOLD_CYCLES   = 15_000;
    localparam int SETTLE_CYCLES      = 16;
    localparam int DRAIN_CYCLES       = 64;
    localparam int RANDOM_PHASES      = 10;
    localparam int BASES_PER_PHASE    = 12;

    // First index past the defined registers, and the top of the index range
    localparam cfg_index_t REG_INDEX_LIMIT = cfg_index_t'(2);
    localparam cfg_index_t REG_TOP_INDEX   = '1;

    logic       clk;
    logic       rst_n = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = '0;
    field_t     cfg_data  = '0;

    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    field_t     s_axis_tdata  = '0;     // [63:0] base_value

    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    field_t     m_axis_tdata;           // [63:0] power_result

    modular_exponentiation_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Stimulus and scoreboard storage
    field_t      base_pending_q[$];
    field_t      power_expected_q[$];
    field_t      modulus_copy;
    field_t      exponent_copy;

    int unsigned idle_pct      = 20;    // chance per cycle of an idle burst
    int unsigned hold_ticket   = 0;     // bumped to request a long hold-off
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned send_gap      = 0;
    int unsigned recv_gap      = 0;
    logic        base_taken    = 1'b0;  // s_axis transaction at last posedge

    int unsigned cycle_count      = 0;
    int unsigned error_count      = 0;
    int unsigned bases_accepted   = 0;
    int unsigned results_checked  = 0;
    int unsigned zero_results     = 0;
    int unsigned settings_applied = 0;

    // ------------------------------------------------------------------------
    // Golden arithmetic
    // ------------------------------------------------------------------------
    function automatic operand_t mul_mod_exact(operand_t a, operand_t b, operand_t m);
        logic [2*OPW-1:0] wide;
        wide = (2*OPW)'(a) * (2*OPW)'(b);
        return operand_t'(wide % (2*OPW)'(m));
    endfunction

    // base^exponent mod modulus, right-to-left over the exponent bits
    function automatic field_t power_mod(field_t base_in, field_t mod_reg, field_t exp_reg);
        operand_t m;
        operand_t e;
        operand_t sq;
        operand_t acc;
        m = operand_t'(mod_reg);
        e = operand_t'(exp_reg);
        if (m == '0)
            return '0;
        sq = operand_t'(base_in) % m;
        // base folding to zero wins over a zero exponent; also covers modulus 1
        if (sq == '0)
            return '0;
        acc = operand_t'(1);
        for (int i = 0; i < OPW; i++)
        begin
            if (e[i])
                acc = mul_mod_exact(acc, sq, m);
            sq = mul_mod_exact(sq, sq, m);
        end
        return field_t'(acc);
    endfunction

    function automatic field_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic field_t random_base(field_t m);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return m * $urandom_range(1, 5);   // multiple of the modulus, truncated to 64 bits
            2:       return m - 1;
            3:       return '1;
            4:       return field_t'(1);
            default: return rand64();
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycle_count, power_expected_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: one base per transaction, random idle bursts between them
    // ------------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end
        else if (s_axis_tvalid && !base_taken)
        begin
            // offered but not taken yet: hold the data
        end
        else if (send_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= send_gap - 1;
        end
        else if (base_pending_q.size() != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= $urandom_range(0, 7);
        end
        else if (base_pending_q.size() != 0)
        begin
            s_axis_tdata  <= base_pending_q.pop_front();
            s_axis_tvalid <= 1'b1;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready with random stall bursts; a long hold-off on request
    // lets the core fill its output register and back up the input side
    // ------------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_served   <= 0;
            recv_gap      <= 0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_ticket != hold_served)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= LONG_HOLD_CYCLES;
            hold_served   <= hold_ticket;
        end
        else if (recv_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= recv_gap - 1;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= $urandom_range(0, 7);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: register copy, prediction on input, comparison on output
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_copy  <= field_t'(1);
            exponent_copy <= '0;
            base_taken    <= 1'b0;
        end
        else
        begin
            base_taken <= s_axis_tvalid && s_axis_tready;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODULUS:  modulus_copy  <= cfg_data;
                    REG_EXPONENT: exponent_copy <= cfg_data;
                    default: ;  // undefined index, write dropped
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                power_expected_q.push_back(power_mod(s_axis_tdata, modulus_copy,
                                                     exponent_copy));
                bases_accepted++;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (power_expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    field_t want;
                    want = power_expected_q.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: power_result mismatch, expected %h, got %h",
                                 $time, want, m_axis_tdata);
                        error_count++;
                    end
                    if (want == '0)
                        zero_results++;
                    results_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------

    // Core is idle once nothing is queued, offered or outstanding
    task automatic wait_idle();
        @(posedge clk);
        while (base_pending_q.size() != 0 || s_axis_tvalid || power_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, field_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Program both registers, optionally followed by a write to an
    // undefined index that must leave them untouched
    task automatic set_registers(field_t m, field_t e, int unsigned idle,
                                 bit add_stray, cfg_index_t stray_idx);
        wait_idle();
        idle_pct = idle;
        write_register(REG_MODULUS, m);
        write_register(REG_EXPONENT, e);
        if (add_stray)
            write_register(stray_idx, rand64());
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        field_t m;
        field_t e;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting: modulus one, so everything folds to zero
        base_pending_q.push_back('0);
        base_pending_q.push_back(field_t'(5));
        base_pending_q.push_back('1);

        // Zero modulus
        set_registers('0, field_t'(5), 20, 1'b0, REG_INDEX_LIMIT);
        base_pending_q.push_back(field_t'(7));
        base_pending_q.push_back('1);

        // Full-width modulus and exponent
        set_registers('1, '1, 20, 1'b0, REG_INDEX_LIMIT);
        base_pending_q.push_back('0);
        base_pending_q.push_back(field_t'(1));
        base_pending_q.push_back(field_t'(2));
        base_pending_q.push_back('1);                  // equals the modulus
        base_pending_q.push_back(64'hFFFF_FFFF_FFFF_FFFE);

        // Small modulus, zero exponent; top index write must be ignored
        set_registers(field_t'(13), '0, 0, 1'b1, REG_TOP_INDEX);
        base_pending_q.push_back('0);                  // zero base, zero exponent
        base_pending_q.push_back(field_t'(26));
        base_pending_q.push_back(field_t'(5));
        base_pending_q.push_back('1);

        // Largest 64-bit prime, exponent with only the top bit set
        set_registers(64'hFFFF_FFFF_FFFF_FFC5, 64'h8000_0000_0000_0000, 30, 1'b0,
                      REG_INDEX_LIMIT);
        base_pending_q.push_back(field_t'(3));
        base_pending_q.push_back('1);
        base_pending_q.push_back(64'h5555_5555_5555_5555);
        base_pending_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);

        // Modulus two, exponent one
        set_registers(field_t'(2), field_t'(1), 20, 1'b1, REG_INDEX_LIMIT);
        base_pending_q.push_back(field_t'(1));
        base_pending_q.push_back(64'h8000_0000_0000_0003);

        // Random settings; the last two phases run with no idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 11))
                0:       m = '0;
                1:       m = field_t'(1);
                2:       m = '1;
                3:       m = field_t'($urandom_range(2, 255));
                4:       m = rand64() | 64'h8000_0000_0000_0000;
                default: m = rand64();
            endcase
            case ($urandom_range(0, 7))
                0:       e = '0;
                1:       e = '1;
                2:       e = field_t'($urandom_range(0, 15));
                3:       e = field_t'(1);
                default: e = rand64();
            endcase
            set_registers(m, e,
                          (p >= RANDOM_PHASES - 2 || $urandom_range(0, 3) == 0) ? 0 : 25,
                          $urandom_range(0, 2) == 0,
                          cfg_index_t'($urandom_range(2**CFG_IDX_W - 1, REG_INDEX_LIMIT)));
            // Receiver stalls for a long stretch while bases keep coming
            if (p == 1)
                hold_ticket++;
            for (int k = 0; k < BASES_PER_PHASE; k++)
                base_pending_q.push_back(random_base(m));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (power_expected_q.size() != 0)
        begin
            $display("%0t: results never returned, expected %0d more, got 0",
                     $time, power_expected_q.size());
            error_count++;
        end

        $display("Run covered %0d bases under %0d register settings, %0d results checked",
                 bases_accepted, settings_applied, results_checked);
        $display("%0d results were zero, %0d mismatches", zero_results, error_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/mexp_pkg.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation_core.sv
tb/tb_top.sv
